// ===== src/iso8601_to_epoch_parser_assert.svh =====
// Assertion helpers for the timestamp parser.
`ifndef ISO8601_TO_EPOCH_PARSER_ASSERT_SVH
`define ISO8601_TO_EPOCH_PARSER_ASSERT_SVH

// Same-cycle implication.
`define ISO_EP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ISO_EP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/iso_ep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iso_ep_pkg;

   localparam logic [37:0] MIN_EPOCH_RESET = 38'd1577836800;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_T     = 8'h54;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_EARLY     = 2'd2;

   typedef enum logic [3:0] {
      FIELD_YEAR    = 4'd0,
      FIELD_MONTH   = 4'd1,
      FIELD_DAY     = 4'd2,
      FIELD_HOUR    = 4'd3,
      FIELD_MINUTE  = 4'd4,
      FIELD_SECOND  = 4'd5,
      FIELD_OFFHOUR = 4'd6,
      FIELD_OFFMIN  = 4'd7,
      FIELD_DONE    = 4'd8
   } field_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_STAGE1,
      STATE_STAGE2,
      STATE_STAGE3,
      STATE_STAGE4,
      STATE_STAGE5,
      STATE_WRITE
   } state_type;

   typedef struct packed {
      logic take;
      logic stage1;
      logic stage2;
      logic stage3;
      logic stage4;
      logic stage5;
      logic load;
   } dp_cmd_type;

endpackage

`default_nettype wire

// ===== src/iso_ep_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iso_ep_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tlast,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output iso_ep_pkg::dp_cmd_type     cmd
);

   iso_ep_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iso_ep_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         iso_ep_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (req_tlast) begin
                  state_in = iso_ep_pkg::STATE_STAGE1;
               end
            end
         end
         iso_ep_pkg::STATE_STAGE1: begin
            cmd.stage1 = 1'b1;
            state_in   = iso_ep_pkg::STATE_STAGE2;
         end
         iso_ep_pkg::STATE_STAGE2: begin
            cmd.stage2 = 1'b1;
            state_in   = iso_ep_pkg::STATE_STAGE3;
         end
         iso_ep_pkg::STATE_STAGE3: begin
            cmd.stage3 = 1'b1;
            state_in   = iso_ep_pkg::STATE_STAGE4;
         end
         iso_ep_pkg::STATE_STAGE4: begin
            cmd.stage4 = 1'b1;
            state_in   = iso_ep_pkg::STATE_STAGE5;
         end
         iso_ep_pkg::STATE_STAGE5: begin
            cmd.stage5 = 1'b1;
            state_in   = iso_ep_pkg::STATE_WRITE;
         end
         iso_ep_pkg::STATE_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = iso_ep_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = iso_ep_pkg::STATE_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== src/iso_ep_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module iso_ep_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire iso_ep_pkg::dp_cmd_type cmd,
   input  wire logic [7:0]            character,
   input  wire logic                  csr_wen,
   input  wire logic [37:0]           csr_wdata,
   output logic [38:0]                epoch_seconds,
   output logic [1:0]                 status
);

   // parse state
   iso_ep_pkg::field_type fi_ff, fi_in;
   logic [2:0]  dc_ff, dc_in;
   logic [13:0] acc_ff, acc_in;
   logic [13:0] year_ff, year_in;
   logic [6:0]  month_ff, month_in;
   logic [6:0]  day_ff, day_in;
   logic [6:0]  hour_ff, hour_in;
   logic [6:0]  minute_ff, minute_in;
   logic [6:0]  second_ff, second_in;
   logic        neg_ff, neg_in;
   logic [6:0]  oh_ff, oh_in;
   logic        err_ff, err_in;
   logic [37:0] min_ff;

   logic        is_digit;
   logic [2:0]  width;
   logic        sep_ok;

   // conversion pipeline
   logic               lt3;
   logic signed [14:0] yfm_ff, yfm_in;
   logic [6:0]         mfm;
   logic [15:0]        era_prod;
   logic signed [5:0]  era_ff, era_in;
   logic [14:0]        num_ff, num_in;
   logic [18:0]        tod;
   logic [18:0]        off;
   logic signed [20:0] tdelta_ff, tdelta_in;

   logic signed [16:0] era400;
   logic signed [16:0] yoe_full;
   logic [8:0]         yoe_ff, yoe_in;
   logic [26:0]        doy_prod;
   logic [11:0]        doyq_ff, doyq_in;
   logic signed [23:0] era146_ff, era146_in;

   logic [12:0]        yoeq_prod;
   logic [6:0]         yoe4_ff, yoe4_in;
   logic [2:0]         yoeq_ff, yoeq_in;
   logic [17:0]        y365_ff, y365_in;
   logic signed [13:0] doy_ff, doy_in;

   logic signed [23:0] days_ff, days_in;

   logic signed [41:0] secs_prod;
   logic signed [39:0] epoch_ff, epoch_in;

   logic        fmt_ok;
   logic [38:0] out_epoch_ff;
   logic [1:0]  out_status_ff;

   always_comb begin
      is_digit = (character >= iso_ep_pkg::CHAR_ZERO) && (character <= iso_ep_pkg::CHAR_NINE);
      width    = (fi_ff == iso_ep_pkg::FIELD_YEAR) ? 3'd4 : 3'd2;
      unique case (fi_ff)
         iso_ep_pkg::FIELD_YEAR, iso_ep_pkg::FIELD_MONTH:
            sep_ok = (character == iso_ep_pkg::CHAR_DASH);
         iso_ep_pkg::FIELD_DAY:
            sep_ok = (character == iso_ep_pkg::CHAR_T);
         iso_ep_pkg::FIELD_HOUR, iso_ep_pkg::FIELD_MINUTE, iso_ep_pkg::FIELD_OFFHOUR:
            sep_ok = (character == iso_ep_pkg::CHAR_COLON);
         iso_ep_pkg::FIELD_SECOND:
            sep_ok = (character != iso_ep_pkg::CHAR_NUL);
         default:
            sep_ok = 1'b1;
      endcase
   end

   always_comb begin
      fi_in     = fi_ff;
      dc_in     = dc_ff;
      acc_in    = acc_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      neg_in    = neg_ff;
      oh_in     = oh_ff;
      err_in    = err_ff;
      if (cmd.load) begin
         fi_in     = iso_ep_pkg::FIELD_YEAR;
         dc_in     = '0;
         acc_in    = '0;
         year_in   = '0;
         month_in  = '0;
         day_in    = '0;
         hour_in   = '0;
         minute_in = '0;
         second_in = '0;
         neg_in    = 1'b0;
         oh_in     = '0;
         err_in    = 1'b0;
      end else if (cmd.take && !err_ff && (fi_ff != iso_ep_pkg::FIELD_DONE)) begin
         if (is_digit && (dc_ff < width)) begin
            acc_in = acc_ff * 14'd10 + {10'd0, character[3:0]};
            dc_in  = dc_ff + 3'd1;
         end else if ((dc_ff == 3'd0) || !sep_ok) begin
            err_in = 1'b1;
         end else begin
            unique case (fi_ff)
               iso_ep_pkg::FIELD_YEAR:    year_in   = acc_ff;
               iso_ep_pkg::FIELD_MONTH:   month_in  = acc_ff[6:0];
               iso_ep_pkg::FIELD_DAY:     day_in    = acc_ff[6:0];
               iso_ep_pkg::FIELD_HOUR:    hour_in   = acc_ff[6:0];
               iso_ep_pkg::FIELD_MINUTE:  minute_in = acc_ff[6:0];
               iso_ep_pkg::FIELD_SECOND: begin
                  second_in = acc_ff[6:0];
                  neg_in    = (character == iso_ep_pkg::CHAR_DASH);
               end
               iso_ep_pkg::FIELD_OFFHOUR: oh_in     = acc_ff[6:0];
               default: begin
               end
            endcase
            fi_in = iso_ep_pkg::field_type'(fi_ff + 4'd1);
            if (fi_ff != iso_ep_pkg::FIELD_OFFMIN) begin
               acc_in = '0;
               dc_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fi_ff     <= iso_ep_pkg::FIELD_YEAR;
         dc_ff     <= '0;
         acc_ff    <= '0;
         year_ff   <= '0;
         month_ff  <= '0;
         day_ff    <= '0;
         hour_ff   <= '0;
         minute_ff <= '0;
         second_ff <= '0;
         neg_ff    <= 1'b0;
         oh_ff     <= '0;
         err_ff    <= 1'b0;
         min_ff    <= iso_ep_pkg::MIN_EPOCH_RESET;
      end else begin
         fi_ff     <= fi_in;
         dc_ff     <= dc_in;
         acc_ff    <= acc_in;
         year_ff   <= year_in;
         month_ff  <= month_in;
         day_ff    <= day_in;
         hour_ff   <= hour_in;
         minute_ff <= minute_in;
         second_ff <= second_in;
         neg_ff    <= neg_in;
         oh_ff     <= oh_in;
         err_ff    <= err_in;
         if (csr_wen) begin
            min_ff <= csr_wdata;
         end
      end
   end

   // stage 1: shift year to March start, era estimate, time of day adjusted by the offset
   always_comb begin
      lt3      = (month_ff < 7'd3);
      yfm_in   = $signed({1'b0, year_ff}) - $signed({14'd0, lt3});
      mfm      = lt3 ? (month_ff + 7'd9) : (month_ff - 7'd3);
      era_prod = 16'(yfm_in[13:4]) * 16'd41;
      era_in   = yfm_in[14] ? 6'sh3F : $signed(era_prod[15:10]);
      num_in   = 15'(mfm) * 15'd153 + 15'd2;
      tod      = 19'(hour_ff) * 19'd3600 + 19'(minute_ff) * 19'd60 + 19'(second_ff);
      off      = 19'(oh_ff) * 19'd3600 + 19'(acc_ff[6:0]) * 19'd60;
      tdelta_in = neg_ff ? ($signed({2'b00, tod}) + $signed({2'b00, off}))
                         : ($signed({2'b00, tod}) - $signed({2'b00, off}));
   end

   // stage 2: year of era, day of year quotient, era days
   always_comb begin
      era400    = $signed({{11{era_ff[5]}}, era_ff}) * 17'sd400;
      yoe_full  = $signed({{2{yfm_ff[14]}}, yfm_ff}) - era400;
      yoe_in    = yoe_full[8:0];
      doy_prod  = 27'(num_ff) * 27'd3277;
      doyq_in   = doy_prod[25:14];
      era146_in = $signed({{18{era_ff[5]}}, era_ff}) * 24'sd146097;
   end

   // stage 3: leap terms and day of year
   always_comb begin
      yoe4_in   = yoe_ff[8:2];
      yoeq_prod = 13'(yoe4_in) * 13'd41;
      yoeq_in   = yoeq_prod[12:10];
      y365_in   = 18'(yoe_ff) * 18'd365;
      doy_in    = $signed({2'b00, doyq_ff}) + $signed({7'd0, day_ff}) - 14'sd1;
   end

   // stage 4: days since epoch
   always_comb begin
      days_in = era146_ff + $signed({6'd0, y365_ff}) + $signed({17'd0, yoe4_ff})
              - $signed({21'd0, yoeq_ff}) + $signed({{10{doy_ff[13]}}, doy_ff})
              - 24'sd719468;
   end

   // stage 5: seconds
   always_comb begin
      secs_prod = days_ff * 18'sd86400;
      epoch_in  = secs_prod[39:0] + $signed({{19{tdelta_ff[20]}}, tdelta_ff});
   end

   always_ff @(posedge clock) begin
      if (cmd.stage1) begin
         yfm_ff    <= yfm_in;
         era_ff    <= era_in;
         num_ff    <= num_in;
         tdelta_ff <= tdelta_in;
      end
      if (cmd.stage2) begin
         yoe_ff    <= yoe_in;
         doyq_ff   <= doyq_in;
         era146_ff <= era146_in;
      end
      if (cmd.stage3) begin
         yoe4_ff <= yoe4_in;
         yoeq_ff <= yoeq_in;
         y365_ff <= y365_in;
         doy_ff  <= doy_in;
      end
      if (cmd.stage4) begin
         days_ff <= days_in;
      end
      if (cmd.stage5) begin
         epoch_ff <= epoch_in;
      end
   end

   assign fmt_ok = !err_ff && ((fi_ff == iso_ep_pkg::FIELD_DONE) ||
                               ((fi_ff == iso_ep_pkg::FIELD_OFFMIN) && (dc_ff != 3'd0)));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (!fmt_ok) begin
            out_epoch_ff  <= '0;
            out_status_ff <= iso_ep_pkg::STATUS_MALFORMED;
         end else begin
            out_epoch_ff <= epoch_ff[38:0];
            if (epoch_ff >= $signed({2'b00, min_ff})) begin
               out_status_ff <= iso_ep_pkg::STATUS_OK;
            end else begin
               out_status_ff <= iso_ep_pkg::STATUS_EARLY;
            end
         end
      end
   end

   assign epoch_seconds = out_epoch_ff;
   assign status        = out_status_ff;

endmodule

`default_nettype wire

// ===== src/iso8601_to_epoch_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Parses YYYY-MM-DDTHH:MM:SS, a sign character and HH:MM, one character per word,
// and returns Unix seconds and a status on the word marked tlast. A word
// without tlast is accepted whenever the parser is idle. A tlast word is parsed,
// then passes through five days-from-civil pipeline stages (constant multiplies
// and adds split across the stages) and then loads the result register; that
// last step waits while an earlier result is still held. Status 0 is valid, 1 is
// malformed text (seconds then read zero), 2 is earlier than the minimum epoch
// held in the CSR, which resets to 1577836800.

`include "iso8601_to_epoch_parser_assert.svh"

module iso8601_to_epoch_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [38:0] epoch_seconds, [39] zero
   output logic [1:0]       rsp_tuser,   // [1:0] status
   input  wire logic        csr_wen,
   input  wire logic [37:0] csr_wdata
);

   iso_ep_pkg::dp_cmd_type cmd;
   logic [38:0] epoch_seconds;
   logic [1:0]  status;

   iso_ep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   iso_ep_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .character     (req_tdata),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .epoch_seconds (epoch_seconds),
      .status        (status)
   );

   assign rsp_tdata = {1'b0, epoch_seconds};
   assign rsp_tuser = status;

   `ISO_EP_ASSERT_NEXT(a_last_stalls_input, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "input taken during conversion")
   `ISO_EP_ASSERT_IMPL(a_cmd_onehot, clock, reset, 1'b1, $onehot0({cmd.take, cmd.stage1, cmd.stage2, cmd.stage3, cmd.stage4, cmd.stage5, cmd.load}), "overlapping datapath commands")
   `ISO_EP_ASSERT_NEXT(a_load_shows_result, clock, reset, cmd.load, rsp_tvalid, "loaded result not presented")
   `ISO_EP_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid, rsp_tuser != 2'd3, "undefined status code")

endmodule

`default_nettype wire

// ===== verif/iso8601_to_epoch_parser_tb.sv =====
`timescale 1ns / 1ps

module iso8601_to_epoch_parser_tb;

   localparam logic [7:0]  NUL_MARK   = "#";
   localparam logic [37:0] MIN_EPOCH_MAX = 38'h3F_FFFF_FFFF;
   localparam int          PHASE_WORDS = 400;
   localparam int          WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic        fixed;
      logic [38:0] secs;
      logic [1:0]  status;
   } text_word_type;

   typedef struct packed {
      logic [38:0] secs;
      logic [1:0]  status;
   } epoch_result_type;

   typedef struct {
      string       text;
      bit          fixed;
      logic [38:0] secs;
      logic [1:0]  status;
   } text_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = 8'd0;    // [7:0] character
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;           // [38:0] epoch_seconds, [39] zero
   logic [1:0]   rsp_tuser;           // [1:0] status
   logic         csr_wen = 1'b0;
   logic [37:0]  csr_wdata = 38'd0;

   text_word_type    cur_word = '0;
   epoch_result_type expected_epochs[$];
   logic [7:0]       gen_text[$];
   bit               idle_on = 1'b1;
   int unsigned      rsp_hold = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      quiet_cycles = 0;

   // timestamp parse state
   logic [37:0]           min_epoch_cfg = iso_ep_pkg::MIN_EPOCH_RESET;
   iso_ep_pkg::field_type ts_field = iso_ep_pkg::FIELD_YEAR;
   logic [2:0]            ts_digits = '0;
   logic [13:0]           ts_acc = '0;
   logic [13:0]           ts_year = '0;
   logic [6:0]            ts_month = '0;
   logic [6:0]            ts_day = '0;
   logic [6:0]            ts_hour = '0;
   logic [6:0]            ts_minute = '0;
   logic [6:0]            ts_second = '0;
   logic                  ts_minus = 1'b0;
   logic [6:0]            ts_offhour = '0;
   logic                  ts_bad = 1'b0;

   // '#' stands for a NUL character
   text_row_type dir_rows[19] = '{
      '{"1970-01-01T00:00:00+00:00", 1'b1, 39'd0, iso_ep_pkg::STATUS_EARLY},
      '{"2020-01-01T00:00:00+00:00", 1'b1, 39'd1577836800, iso_ep_pkg::STATUS_OK},
      '{"9999-99-99T99:99:99-99:99", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"0-0-0T0:0:0+99:99", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"X", 1'b1, 39'd0, iso_ep_pkg::STATUS_MALFORMED},
      '{"2020/01-01T00:00:00+00:00", 1'b1, 39'd0, iso_ep_pkg::STATUS_MALFORMED},
      '{"-01", 1'b1, 39'd0, iso_ep_pkg::STATUS_MALFORMED},
      '{"20201-01-01T00:00:00+00:00", 1'b1, 39'd0, iso_ep_pkg::STATUS_MALFORMED},
      '{"2020-01-01T00:00:00+00:", 1'b1, 39'd0, iso_ep_pkg::STATUS_MALFORMED},
      '{"2020-01-01T00:00:00#00:00", 1'b1, 39'd0, iso_ep_pkg::STATUS_MALFORMED},
      '{"2020-#", 1'b1, 39'd0, iso_ep_pkg::STATUS_MALFORMED},
      '{"2020-01-01T00:00:00+00:0#", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"2021-06-15T12:34:56505:30", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"2021-6-15T1:2:3-4:5", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"2021-06-15T12:34:5Z05:30", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"2021-06-15T12:34:56+05:301xyz", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"2000-00-00T00:00:00+00:00", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"2000-02-29T23:59:59+14:00", 1'b0, 39'd0, iso_ep_pkg::STATUS_OK},
      '{"1969-12-31T23:59:59+00:00", 1'b1, 39'h7F_FFFF_FFFF, iso_ep_pkg::STATUS_EARLY}
   };

   iso8601_to_epoch_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic clear_ts_state();
      ts_field = iso_ep_pkg::FIELD_YEAR;
      ts_digits = '0;
      ts_acc = '0;
      ts_year = '0;
      ts_month = '0;
      ts_day = '0;
      ts_hour = '0;
      ts_minute = '0;
      ts_second = '0;
      ts_minus = 1'b0;
      ts_offhour = '0;
      ts_bad = 1'b0;
   endtask

   task automatic parse_ts_char(input logic [7:0] c);
      bit is_digit;
      int unsigned width;
      bit sep_ok;
      is_digit = (c >= iso_ep_pkg::CHAR_ZERO) && (c <= iso_ep_pkg::CHAR_NINE);
      width = (ts_field == iso_ep_pkg::FIELD_YEAR) ? 4 : 2;
      if (is_digit && ts_digits < width) begin
         ts_acc = 14'(ts_acc * 10 + int'(c - iso_ep_pkg::CHAR_ZERO));
         ts_digits = ts_digits + 3'd1;
         return;
      end
      case (ts_field)
         iso_ep_pkg::FIELD_YEAR, iso_ep_pkg::FIELD_MONTH:
            sep_ok = (c == iso_ep_pkg::CHAR_DASH);
         iso_ep_pkg::FIELD_DAY: sep_ok = (c == iso_ep_pkg::CHAR_T);
         iso_ep_pkg::FIELD_HOUR, iso_ep_pkg::FIELD_MINUTE, iso_ep_pkg::FIELD_OFFHOUR:
            sep_ok = (c == iso_ep_pkg::CHAR_COLON);
         iso_ep_pkg::FIELD_SECOND: sep_ok = (c != iso_ep_pkg::CHAR_NUL);
         default: sep_ok = 1'b1;
      endcase
      if (ts_digits == 0 || !sep_ok) begin
         ts_bad = 1'b1;
         return;
      end
      case (ts_field)
         iso_ep_pkg::FIELD_YEAR: ts_year = ts_acc;
         iso_ep_pkg::FIELD_MONTH: ts_month = 7'(ts_acc);
         iso_ep_pkg::FIELD_DAY: ts_day = 7'(ts_acc);
         iso_ep_pkg::FIELD_HOUR: ts_hour = 7'(ts_acc);
         iso_ep_pkg::FIELD_MINUTE: ts_minute = 7'(ts_acc);
         iso_ep_pkg::FIELD_SECOND: begin
            ts_second = 7'(ts_acc);
            ts_minus = (c == iso_ep_pkg::CHAR_DASH);
         end
         iso_ep_pkg::FIELD_OFFHOUR: ts_offhour = 7'(ts_acc);
         default: ;
      endcase
      ts_field = iso_ep_pkg::field_type'(ts_field + 4'd1);
      if (ts_field != iso_ep_pkg::FIELD_DONE) begin
         ts_acc = '0;
         ts_digits = '0;
      end
   endtask

   function automatic longint civil_to_epoch();
      longint yr, m, yfm, mfm, era, yoe, doy, doe, days, lcl, off;
      yr = ts_year;
      m = ts_month;
      yfm = yr - ((m < 3) ? 1 : 0);
      mfm = (m < 3) ? m + 9 : m - 3;
      era = ((yfm >= 0) ? yfm : yfm - 399) / 400;
      yoe = yfm - era * 400;
      doy = (153 * mfm + 2) / 5 + longint'(ts_day) - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      lcl = days * 86400 + longint'(ts_hour) * 3600 + longint'(ts_minute) * 60
            + longint'(ts_second);
      off = (longint'(ts_offhour) * 60 + longint'(ts_acc)) * 60;
      return ts_minus ? lcl + off : lcl - off;
   endfunction

   always @(posedge clock) begin : track
      epoch_result_type er;
      longint secs;
      longint floor_secs;
      if (reset) begin
         clear_ts_state();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_epochs.size() == 0) begin
               report_mismatch($sformatf("unexpected word epoch=%0d status=%0d",
                  $signed(rsp_tdata[38:0]), rsp_tuser));
            end else begin
               er = expected_epochs.pop_front();
               if (rsp_tdata !== {1'b0, er.secs})
                  report_mismatch($sformatf("epoch %0d, want %0d",
                     $signed(rsp_tdata[38:0]), $signed(er.secs)));
               if (rsp_tuser !== er.status)
                  report_mismatch($sformatf("status %0d, want %0d", rsp_tuser, er.status));
            end
         end
         if (req_tvalid && req_tready) begin
            if (!ts_bad && ts_field != iso_ep_pkg::FIELD_DONE)
               parse_ts_char(cur_word.ch);
            if (cur_word.last) begin
               if (cur_word.fixed) begin
                  er.secs = cur_word.secs;
                  er.status = cur_word.status;
               end else if (!ts_bad && (ts_field == iso_ep_pkg::FIELD_DONE ||
                            (ts_field == iso_ep_pkg::FIELD_OFFMIN && ts_digits >= 1))) begin
                  secs = civil_to_epoch();
                  floor_secs = min_epoch_cfg;
                  er.secs = secs[38:0];
                  er.status = (secs >= floor_secs) ? iso_ep_pkg::STATUS_OK
                                                   : iso_ep_pkg::STATUS_EARLY;
               end else begin
                  er.secs = '0;
                  er.status = iso_ep_pkg::STATUS_MALFORMED;
               end
               expected_epochs.push_back(er);
               clear_ts_state();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_hold <= $urandom_range(1, 6) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL iso8601_to_epoch_parser");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input text_word_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w.ch;
      req_tlast <= w.last;
      cur_word <= w;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic await_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_epochs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_min_epoch(input logic [37:0] v);
      await_idle();
      csr_wen <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      min_epoch_cfg = v;
   endtask

   task automatic push_digits(input int n);
      repeat (n) gen_text.push_back(iso_ep_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic build_timestamp();
      int r;
      gen_text.delete();
      push_digits($urandom_range(1, 4));
      gen_text.push_back(iso_ep_pkg::CHAR_DASH);
      push_digits($urandom_range(1, 2));
      gen_text.push_back(iso_ep_pkg::CHAR_DASH);
      push_digits($urandom_range(1, 2));
      gen_text.push_back(iso_ep_pkg::CHAR_T);
      push_digits($urandom_range(1, 2));
      gen_text.push_back(iso_ep_pkg::CHAR_COLON);
      push_digits($urandom_range(1, 2));
      gen_text.push_back(iso_ep_pkg::CHAR_COLON);
      push_digits($urandom_range(1, 2));
      r = $urandom_range(0, 9);
      if (r < 4)
         gen_text.push_back("+");
      else if (r < 8)
         gen_text.push_back(iso_ep_pkg::CHAR_DASH);
      else
         gen_text.push_back(8'($urandom_range(0, 255)));
      push_digits($urandom_range(1, 2));
      gen_text.push_back(iso_ep_pkg::CHAR_COLON);
      push_digits($urandom_range(1, 2));
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) gen_text.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_text(inout int sent);
      text_word_type w;
      int kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         gen_text.delete();
         repeat ($urandom_range(1, 4)) gen_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         build_timestamp();
         if (kind == 1)
            gen_text[$urandom_range(0, gen_text.size() - 1)] = 8'($urandom_range(0, 255));
         else if (kind == 2)
            gen_text = gen_text[0:$urandom_range(0, gen_text.size() - 1)];
      end
      w = '0;
      foreach (gen_text[i]) begin
         w.ch = gen_text[i];
         w.last = (i == gen_text.size() - 1);
         send_word(w);
      end
      sent += gen_text.size();
   endtask

   initial begin
      text_word_type w;
      logic [37:0] phase_min[5];
      int sent;
      int len;
      phase_min[0] = 38'd0;
      phase_min[1] = MIN_EPOCH_MAX;
      phase_min[2] = 38'({6'($urandom_range(0, 63)), 32'($urandom())});
      phase_min[3] = 38'($urandom());
      phase_min[4] = iso_ep_pkg::MIN_EPOCH_RESET;

      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         len = dir_rows[r].text.len();
         for (int i = 0; i < len; i++) begin
            w.ch = (dir_rows[r].text[i] == NUL_MARK) ? iso_ep_pkg::CHAR_NUL
                                                     : dir_rows[r].text[i];
            w.last = (i == len - 1);
            w.fixed = dir_rows[r].fixed && w.last;
            w.secs = dir_rows[r].secs;
            w.status = dir_rows[r].status;
            send_word(w);
         end
      end

      for (int p = 0; p < 5; p++) begin
         write_min_epoch(phase_min[p]);
         idle_on = (p != 4);
         sent = 0;
         while (sent < PHASE_WORDS) send_random_text(sent);
      end

      await_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS iso8601_to_epoch_parser");
      else
         $display("FAIL iso8601_to_epoch_parser");
      $finish;
   end

endmodule
